// ===== rtl/core/channel_range_statistics_monitor_assert.svh =====
// Assertion macros for the channel range statistics monitor.
// Used by the top level only; no other dependencies.
`ifndef CHANNEL_RANGE_STATISTICS_MONITOR_ASSERT_SVH
`define CHANNEL_RANGE_STATISTICS_MONITOR_ASSERT_SVH

// same-cycle implication
`define CRSM_ASSERT_IMP(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define CRSM_ASSERT_NXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/crsm_pkg.sv =====
// Shared types and constants of the channel range statistics monitor.
// No dependencies.
`default_nettype none
package crsm_pkg;

    localparam int SAMPLE_W   = 48;
    localparam int COUNT_W    = 32;
    localparam int FRAC       = 24;
    localparam int FRAC_CLAMP = 40;

    typedef enum logic [1:0] {
        OP_OBSERVE = 2'd0,
        OP_READ    = 2'd1,
        OP_CLEAR   = 2'd2
    } crsm_op_t;

    // one channel entry as stored in the statistics memory
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] min_val;
        logic signed [SAMPLE_W-1:0] max_val;
        logic        [SAMPLE_W-1:0] abs_max;
        logic        [SAMPLE_W-1:0] step;
        logic signed [SAMPLE_W-1:0] last;
        logic        [COUNT_W-1:0]  count;
    } crsm_entry_t;

    typedef struct packed {
        logic diff_load;  // register the step difference
        logic first;      // entry not yet valid: initialize it
    } crsm_upd_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/crsm_mem.sv =====
// Statistics memory: one entry per channel, one write and one registered read port.
// Depends on crsm_pkg.
`default_nettype none
module crsm_mem #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  wire                  aclk,
    input  wire                  rd_en,
    input  wire [IDX_W-1:0]      rd_idx,
    output crsm_pkg::crsm_entry_t rd_data,
    input  wire                  wr_en,
    input  wire [IDX_W-1:0]      wr_idx,
    input  crsm_pkg::crsm_entry_t wr_data
);
    import crsm_pkg::*;

    crsm_entry_t mem [DEPTH];
    crsm_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/crsm_update.sv =====
// Read-modify-write datapath: folds one sample into a channel entry.
// Depends on crsm_pkg.
`default_nettype none
module crsm_update (
    input  wire                         aclk,
    input  crsm_pkg::crsm_upd_ctrl_t    ctrl,
    input  wire signed [crsm_pkg::SAMPLE_W-1:0] sample,
    input  crsm_pkg::crsm_entry_t       cur,
    output crsm_pkg::crsm_entry_t       nxt
);
    import crsm_pkg::*;

    logic signed [SAMPLE_W:0]   diff_reg;
    logic        [SAMPLE_W:0]   diff_mag;
    logic        [SAMPLE_W-1:0] step_d;
    logic        [SAMPLE_W-1:0] ax;

    // first step: difference to the previous sample, registered
    always_ff @(posedge aclk) begin
        if (ctrl.diff_load) begin
            diff_reg <= {sample[SAMPLE_W-1], sample} - {cur.last[SAMPLE_W-1], cur.last};
        end
    end

    assign diff_mag = diff_reg[SAMPLE_W] ? (~diff_reg + 1'b1) : diff_reg;
    assign step_d   = diff_mag[SAMPLE_W-1:0];
    assign ax       = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;

    // second step: compares and the new entry
    always_comb begin
        if (ctrl.first) begin
            nxt.min_val = sample;
            nxt.max_val = sample;
            nxt.abs_max = ax;
            nxt.step    = '0;
            nxt.last    = sample;
            nxt.count   = COUNT_W'(1);
        end else begin
            nxt.min_val = (sample < cur.min_val) ? sample : cur.min_val;
            nxt.max_val = (sample > cur.max_val) ? sample : cur.max_val;
            nxt.abs_max = (ax > cur.abs_max) ? ax : cur.abs_max;
            nxt.step    = cur.step;
            if (step_d != '0 && (cur.step == '0 || step_d < cur.step)) begin
                nxt.step = step_d;
            end
            nxt.last  = sample;
            nxt.count = (cur.count != '1) ? cur.count + 1'b1 : cur.count;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/crsm_bits.sv =====
// Bit-width estimator: integer and fraction bits from largest magnitude and smallest step.
// Depends on crsm_pkg.
`default_nettype none
module crsm_bits (
    input  wire                          aclk,
    input  wire                          load,
    input  wire [crsm_pkg::SAMPLE_W-1:0] abs_max,
    input  wire [crsm_pkg::SAMPLE_W-1:0] step,
    output logic [5:0]                   int_width,
    output logic [5:0]                   frac_width,
    output logic [6:0]                   width_sum
);
    import crsm_pkg::*;

    localparam logic [SAMPLE_W:0] FRAC_ONE_M1 = (SAMPLE_W+1)'((64'd1 << FRAC) - 64'd1);

    logic              a_zero_reg;
    logic [SAMPLE_W:0] a_m1_reg;
    logic [SAMPLE_W-1:0] step_reg;
    logic [6:0]        a_len;
    logic [6:0]        d_len;
    logic signed [7:0] fb_raw;

    function automatic logic [6:0] bit_len(input logic [SAMPLE_W:0] x);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i <= SAMPLE_W; i++) begin
            if (x[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

    // ceil(log2(a + 2^FRAC)) is the bit length of a + 2^FRAC - 1
    always_ff @(posedge aclk) begin
        if (load) begin
            a_zero_reg <= (abs_max == '0);
            a_m1_reg   <= {1'b0, abs_max} + FRAC_ONE_M1;
            step_reg   <= step;
        end
    end

    assign a_len  = bit_len(a_m1_reg);
    assign d_len  = bit_len({1'b0, step_reg});
    assign fb_raw = 8'(FRAC) + 8'sd1 - signed'({1'b0, d_len});

    always_comb begin
        int_width = a_zero_reg ? 6'd1 : 6'(a_len - 7'(FRAC) + 7'd1);
        if (step_reg == '0 || fb_raw < 0) begin
            frac_width = '0;
        end else if (fb_raw > 8'(FRAC_CLAMP)) begin
            frac_width = 6'(FRAC_CLAMP);
        end else begin
            frac_width = 6'(fb_raw);
        end
        width_sum = {1'b0, int_width} + {1'b0, frac_width};
    end

endmodule
`default_nettype wire

// ===== rtl/core/channel_range_statistics_monitor.sv =====
// Channel range statistics monitor: a sample observed updates one channel's entry
// in the statistics memory; a read returns the entry plus bit-width estimates; a clear
// empties all channels. Observe and read each pass through memory read, difference or
// width pre-add, and update write or width result; clear and ignored items go straight
// back to idle, and no new item is taken until the block is idle again. The result sits
// in an output register, and observes and clears are accepted while a read result
// waits; a following read stalls only in its width-result state until the previous
// result is taken. Valid bits in flip-flops mark written entries, so clear takes effect
// at once and needs no sweep.
`default_nettype none
module channel_range_statistics_monitor #(
    parameter int CHANNELS = 32
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire [1:0]                          s_operation,
    input  wire [7:0]                          s_channel,
    input  wire signed [crsm_pkg::SAMPLE_W-1:0] s_sample,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic                               m_bad_channel,
    output logic signed [crsm_pkg::SAMPLE_W-1:0] m_seen_min,
    output logic signed [crsm_pkg::SAMPLE_W-1:0] m_seen_max,
    output logic [crsm_pkg::SAMPLE_W-1:0]      m_seen_abs_max,
    output logic [crsm_pkg::SAMPLE_W-1:0]      m_smallest_step,
    output logic [crsm_pkg::COUNT_W-1:0]       m_sample_total,
    output logic [5:0]                         m_int_bits_needed,
    output logic [5:0]                         m_frac_bits_needed,
    output logic [6:0]                         m_total_bits_needed
);
    import crsm_pkg::*;

    `include "channel_range_statistics_monitor_assert.svh"

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [8:0] CHAN_LIM = 9'(CHANNELS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD1 = 5'b00010,
        S_UPD2 = 5'b00100,
        S_RD1  = 5'b01000,
        S_RD2  = 5'b10000
    } crsm_state_t;

    crsm_state_t state_reg, state_next;

    logic [CHANNELS-1:0]        valid_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       hit_reg;   // in range and written
    logic                       bad_reg;   // out-of-range read
    logic                       m_valid_reg;

    logic        accept;
    logic        in_range;
    logic [IDX_W-1:0] s_idx;
    logic        out_load;
    logic        mem_wr_en;
    crsm_op_t    op;

    crsm_entry_t    rd_entry;
    crsm_entry_t    wr_entry;
    crsm_upd_ctrl_t upd_ctrl;
    logic [5:0]     ib;
    logic [5:0]     fb;
    logic [6:0]     tb;

    assign op       = crsm_op_t'(s_operation);
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign s_idx    = s_channel[IDX_W-1:0];
    assign in_range = ({1'b0, s_channel} < CHAN_LIM);
    assign out_load = (state_reg == S_RD2) && (!m_valid_reg || m_ready);
    assign mem_wr_en = (state_reg == S_UPD2);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_OBSERVE: state_next = in_range ? S_UPD1 : S_IDLE;
                        OP_READ:    state_next = S_RD1;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_UPD1:  state_next = S_UPD2;
            S_UPD2:  state_next = S_IDLE;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = out_load ? S_IDLE : S_RD2;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && op == OP_CLEAR) begin
                valid_reg <= '0;
            end else if (mem_wr_en) begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg    <= s_idx;
            sample_reg <= s_sample;
            hit_reg    <= in_range && valid_reg[s_idx];
            bad_reg    <= !in_range;
        end
    end

    crsm_mem #(
        .DEPTH(CHANNELS),
        .IDX_W(IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_idx  (s_idx),
        .rd_data (rd_entry),
        .wr_en   (mem_wr_en),
        .wr_idx  (idx_reg),
        .wr_data (wr_entry)
    );

    assign upd_ctrl.diff_load = (state_reg == S_UPD1);
    assign upd_ctrl.first     = !hit_reg;

    crsm_update u_update (
        .aclk   (aclk),
        .ctrl   (upd_ctrl),
        .sample (sample_reg),
        .cur    (rd_entry),
        .nxt    (wr_entry)
    );

    crsm_bits u_bits (
        .aclk       (aclk),
        .load       (state_reg == S_RD1),
        .abs_max    (hit_reg ? rd_entry.abs_max : '0),
        .step       (hit_reg ? rd_entry.step : '0),
        .int_width  (ib),
        .frac_width (fb),
        .width_sum  (tb)
    );

    // the memory read data holds through the read states: no new read is issued
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_bad_channel       <= bad_reg;
            m_seen_min          <= hit_reg ? rd_entry.min_val : '0;
            m_seen_max          <= hit_reg ? rd_entry.max_val : '0;
            m_seen_abs_max      <= hit_reg ? rd_entry.abs_max : '0;
            m_smallest_step     <= hit_reg ? rd_entry.step : '0;
            m_sample_total      <= hit_reg ? rd_entry.count : '0;
            m_int_bits_needed   <= bad_reg ? '0 : ib;
            m_frac_bits_needed  <= bad_reg ? '0 : fb;
            m_total_bits_needed <= bad_reg ? '0 : tb;
        end
    end

    assign m_valid = m_valid_reg;

    `CRSM_ASSERT_NXT(a_obs_interlock, aclk, aresetn,
        accept && op == OP_OBSERVE && in_range, !s_ready,
        "observe accepted without read-modify-write interlock")

    `CRSM_ASSERT_NXT(a_wr_sets_valid, aclk, aresetn,
        mem_wr_en, valid_reg[$past(idx_reg)],
        "entry written but valid bit not set")

    `CRSM_ASSERT_NXT(a_result_shown, aclk, aresetn,
        out_load, m_valid,
        "read result loaded but not presented")

endmodule
`default_nettype wire
